>>> src/roulette_wheel_selector_defines.svh
// Assertion macros used by the checker file of the selector.
`ifndef ROULETTE_WHEEL_SELECTOR_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTOR_DEFINES_SVH

// Plain property, sampled on the rising clock and switched off in reset.
`define RWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: whenever the antecedent holds, the consequent holds in the same cycle.
`define RWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle.
`define RWS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rws_pkg.sv
package rws_pkg;

  // Fixed field widths of the item formats.
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned FIT_W      = 16;
  localparam int unsigned RND_W      = 16;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned TOTAL_W    = 22;
  localparam int unsigned DATA_IN_W  = 40;
  localparam int unsigned DATA_OUT_W = 8;

  // Reset value of the population count register.
  localparam int unsigned COUNT_RESET = 64;

  // Default sizing of the selector.
  localparam int unsigned POP_MAX_DEF     = 64;
  localparam int unsigned RANDOM_BITS_DEF = 16;

  // Kind of an input item, carried on tuser.
  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SELECT = 1'b1
  } mode_e;

endpackage

>>> src/roulette_wheel_selector.sv
// Channel    Direction  tdata (low bit up)                                    tuser
// s_axis     in         entry_index[5:0], fitness_value[21:6],                mode
//                       random_fraction[37:22], zero[39:38]
// m_axis     out        parent_index[5:0], zero[7:6]                          uniform_fallback
// cfg        in         cfg_wdata_i = population_count, written when cfg_we_i
//
// A write item first reads the old entry, then writes the new one back.
// A select item reads one entry a cycle, first beyond the count for the total in use, then
// in use until the scaled running sum passes the target; a zero total skips the second walk.
// After reset a clearing pass zeroes every memory entry; no item is taken then.
// A finished result waits in the output register, and the next item is accepted meanwhile.
module roulette_wheel_selector #(
  parameter int unsigned POP_MAX     = rws_pkg::POP_MAX_DEF,
  parameter int unsigned RANDOM_BITS = rws_pkg::RANDOM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: population count.
  input  logic                            cfg_we_i,
  input  logic [rws_pkg::COUNT_W-1:0]     cfg_wdata_i,
  // Input items.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry_index, fitness_value, random_fraction, zero padding
  input  logic [rws_pkg::DATA_IN_W-1:0]   s_axis_tdata,
  // mode
  input  logic                            s_axis_tuser,
  // Result items.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // parent_index, zero padding
  output logic [rws_pkg::DATA_OUT_W-1:0]  m_axis_tdata,
  // uniform_fallback
  output logic                            m_axis_tuser
);

  localparam int unsigned AW  = $clog2(POP_MAX);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned RB  = RANDOM_BITS;
  localparam int unsigned TW  = rws_pkg::TOTAL_W;
  localparam int unsigned PW  = RB + TW;
  localparam int unsigned FW  = RB + CW;
  localparam int unsigned SW  = (CW > rws_pkg::COUNT_W) ? CW : rws_pkg::COUNT_W;
  localparam logic [CW-1:0] POP_MAX_C = CW'(POP_MAX);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_TAIL  = 7'b0001000,
    S_MULT  = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  // Input fields.
  logic [rws_pkg::IDX_W-1:0] in_idx;
  logic [rws_pkg::FIT_W-1:0] in_fit;
  logic [rws_pkg::RND_W-1:0] in_rnd;
  logic                      in_accept;

  assign in_idx    = s_axis_tdata[rws_pkg::IDX_W-1:0];
  assign in_fit    = s_axis_tdata[rws_pkg::IDX_W +: rws_pkg::FIT_W];
  assign in_rnd    = s_axis_tdata[rws_pkg::IDX_W + rws_pkg::FIT_W +: rws_pkg::RND_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Control and payload registers.
  state_e                     state_q, state_d;
  logic [CW-1:0]              addr_q, addr_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [AW-1:0]              rd_idx_q, rd_idx_d;
  logic [TW-1:0]              total_q, total_d;
  logic [TW-1:0]              acc_q, acc_d;
  logic [TW-1:0]              tsel_q, tsel_d;
  logic [PW-1:0]              target_q, target_d;
  logic [RB-1:0]              rnd_q, rnd_d;
  logic [CW-1:0]              n_q, n_d;
  logic [AW-1:0]              widx_q, widx_d;
  logic [rws_pkg::FIT_W-1:0]  wfit_q, wfit_d;
  logic                       wok_q, wok_d;
  logic [AW-1:0]              pick_q, pick_d;
  logic                       fb_q, fb_d;
  logic [rws_pkg::COUNT_W-1:0] count_q;
  logic                       out_vld_q, out_vld_d;
  logic [rws_pkg::IDX_W-1:0]  out_idx_q, out_idx_d;
  logic                       out_fb_q, out_fb_d;

  // Fitness memory.
  logic [rws_pkg::FIT_W-1:0]  mem [POP_MAX];
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [rws_pkg::FIT_W-1:0]  mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [rws_pkg::FIT_W-1:0]  mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // Count in use, saturated to the range from two to POP_MAX.
  logic [SW-1:0] count_ext;
  logic [CW-1:0] n_sat;

  assign count_ext = SW'(count_q);

  always_comb begin
    if (count_ext < SW'(2)) begin
      n_sat = CW'(2);
    end else if (count_ext > SW'(POP_MAX)) begin
      n_sat = POP_MAX_C;
    end else begin
      n_sat = CW'(count_ext);
    end
  end

  // Arithmetic of the select walk.
  logic [FW-1:0] fb_prod;
  logic [TW-1:0] run_sum;
  logic [PW-1:0] run_scaled;

  assign fb_prod    = FW'(rnd_q) * FW'(n_q);
  assign run_sum    = acc_q + TW'(mem_rdata_q);
  assign run_scaled = {run_sum, {RB{1'b0}}};

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    total_d   = total_q;
    acc_d     = acc_q;
    tsel_d    = tsel_q;
    target_d  = target_q;
    rnd_d     = rnd_q;
    n_d       = n_q;
    widx_d    = widx_q;
    wfit_d    = wfit_q;
    wok_d     = wok_q;
    pick_d    = pick_q;
    fb_d      = fb_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q[AW-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = addr_q[AW-1:0];

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        addr_d = addr_q + CW'(1);
        if (addr_q == POP_MAX_C - CW'(1)) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser == rws_pkg::MODE_SELECT) begin
            rnd_d   = RB'(in_rnd);
            n_d     = n_sat;
            addr_d  = n_sat;
            acc_d   = '0;
            state_d = S_TAIL;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(in_idx);
            widx_d    = AW'(in_idx);
            wfit_d    = in_fit;
            wok_d     = (32'(in_idx) < POP_MAX);
            state_d   = S_WRITE;
          end
        end
      end

      // Old value is on the read port now: correct the total and store the new one.
      S_WRITE: begin
        if (wok_q) begin
          mem_we    = 1'b1;
          mem_waddr = widx_q;
          mem_wdata = wfit_q;
          total_d   = total_q - TW'(mem_rdata_q) + TW'(wfit_q);
        end
        state_d = S_IDLE;
      end

      // Sum the entries beyond the count; the total in use is what remains.
      S_TAIL: begin
        if (addr_q < POP_MAX_C) begin
          mem_re   = 1'b1;
          addr_d   = addr_q + CW'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          acc_d = acc_q + TW'(mem_rdata_q);
        end else if (!(addr_q < POP_MAX_C)) begin
          tsel_d  = total_q - acc_q;
          state_d = S_MULT;
        end
      end

      // Scale the total by the random fraction, or take the uniform choice.
      S_MULT: begin
        if (tsel_q == '0) begin
          pick_d  = fb_prod[RB +: AW];
          fb_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          target_d = PW'(rnd_q) * PW'(tsel_q);
          acc_d    = '0;
          addr_d   = '0;
          fb_d     = 1'b0;
          state_d  = S_SCAN;
        end
      end

      // Walk the entries in use until the scaled running sum passes the target.
      S_SCAN: begin
        if (addr_q < n_q) begin
          mem_re   = 1'b1;
          addr_d   = addr_q + CW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q[AW-1:0];
        end
        if (rd_vld_q) begin
          acc_d = run_sum;
          if (run_scaled > target_q) begin
            pick_d   = rd_idx_q;
            rd_vld_d = 1'b0;
            state_d  = S_DONE;
          end
        end else if (!(addr_q < n_q)) begin
          pick_d  = AW'(n_q - CW'(1));
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_vld_d = out_vld_q;
    out_idx_d = out_idx_q;
    out_fb_d  = out_fb_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if ((state_q == S_DONE) && (!out_vld_q || m_axis_tready)) begin
      out_vld_d = 1'b1;
      out_idx_d = rws_pkg::IDX_W'(pick_q);
      out_fb_d  = fb_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      addr_q    <= '0;
      rd_vld_q  <= 1'b0;
      total_q   <= '0;
      count_q   <= rws_pkg::COUNT_W'(rws_pkg::COUNT_RESET);
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      rd_vld_q  <= rd_vld_d;
      total_q   <= total_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    acc_q     <= acc_d;
    tsel_q    <= tsel_d;
    target_q  <= target_d;
    rnd_q     <= rnd_d;
    n_q       <= n_d;
    widx_q    <= widx_d;
    wfit_q    <= wfit_d;
    wok_q     <= wok_d;
    pick_q    <= pick_d;
    fb_q      <= fb_d;
    out_idx_q <= out_idx_d;
    out_fb_q  <= out_fb_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(rws_pkg::DATA_OUT_W - rws_pkg::IDX_W){1'b0}}, out_idx_q};
  assign m_axis_tuser  = out_fb_q;

endmodule

>>> src/rws_checker.sv
`include "roulette_wheel_selector_defines.svh"

// Port-level checks of the selector.
module rws_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rws_pkg::DATA_OUT_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tuser
);

  // Number of select items accepted whose result has not yet been taken.
  logic [1:0] pend_q, pend_d;
  logic       sel_acc;
  logic       out_acc;

  assign sel_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == rws_pkg::MODE_SELECT);
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pend_d = pend_q;
    if (sel_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!sel_acc && out_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A result only ever answers a select item.
  `RWS_ASSERT_IMP(a_no_invented_result, m_axis_tvalid, pend_q != 2'd0, "result without select item")

  // At most one select in work and one result waiting.
  `RWS_ASSERT(a_pending_bound, pend_q != 2'd3, "more than two select items outstanding")

  // Every accepted item leaves the block busy, so items are never taken back to back.
  `RWS_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item accepted back to back")

  // A stalled result holds.
  `RWS_ASSERT_NXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (.*);
